// ----- rtl/bmf_pkg.sv -----
// Package for the 2-D box mean filter: constants, payload and queue types.
// Used by every module under rtl/ except bmf_ram.
`default_nettype none
package bmf_pkg;

    // Sizing limits
    localparam int MAX_KERNEL = 7;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int MEAN_W  = 16;
    localparam int SCALE_W = 16;
    localparam int FRAC_SHIFT = 8;
    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

    // Config field widths
    localparam int KSZ_W = 3;
    localparam int DIM_W = 11;

    // Derived widths
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DN_W  = $clog2(MAX_KERNEL / 2 + 1);
    localparam int DLY_W = $clog2((MAX_KERNEL / 2) * (MAX_WIDTH + 1) + 1);
    localparam int POS_W = DIM_W + 1;
    localparam int LB_W  = (MAX_KERNEL - 1) * PIX_W;
    localparam int CSUM_W = $clog2(MAX_KERNEL * 255 + 1);
    localparam int SUM_W  = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
    localparam int PROD_W = SUM_W + SCALE_W;

    // Front/back queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_KERNEL = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_SCALE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } pix_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_value;
        logic              last;
    } res_t;

    // Clamped geometry handed to the front
    typedef struct packed {
        logic [KSZ_W-1:0] k;
        logic [DN_W-1:0]  down;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DLY_W-1:0] delay;
    } geom_t;

    // One column of the window, entry 0 is the newest row
    typedef logic [MAX_KERNEL-1:0][PIX_W-1:0] col_t;

    typedef struct packed {
        col_t                  column;
        logic [MAX_KERNEL-1:0] row_mask;
        logic [MAX_KERNEL-1:0] col_mask;
        logic                  emit;
        logic                  last;
    } qent_t;

endpackage
`default_nettype wire

// ----- rtl/box_mean_filter_2d.sv -----
// Box mean filter, top level: config registers, front, queue, back.
// Throughput: one word per cycle while pix_stall is low. A result moves
// through write stage, queue, s1-s3 and output regs; res_stall holds it.
// Results trail the input by down*width+down words; drain words flush them.
// Reset (async, active low) clears position, queue and valid flags and loads
// k=3, 640x480, scale 7282; the line buffer needs no clearing pass.
`default_nettype none
module box_mean_filter_2d (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pix_valid,
    output logic                        pix_stall,
    input  bmf_pkg::pix_t               pix,
    output logic                        res_valid,
    input  logic                        res_stall,
    output bmf_pkg::res_t               res,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [bmf_pkg::SCALE_W-1:0] cfg_data
);
    import bmf_pkg::*;

    logic [KSZ_W-1:0]   kernel_size_reg;
    logic [DIM_W-1:0]   image_width_reg, image_height_reg;
    logic [SCALE_W-1:0] scale_recip_reg;
    logic               restart;
    geom_t              geom;
    logic               push, pop;
    qent_t              push_data, q_data;
    logic [QCW-1:0]     q_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_size_reg  <= KSZ_W'(3);
            image_width_reg  <= DIM_W'(640);
            image_height_reg <= DIM_W'(480);
            scale_recip_reg  <= SCALE_W'(7282);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KERNEL: kernel_size_reg  <= cfg_data[KSZ_W-1:0];
                REG_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                REG_SCALE:  scale_recip_reg  <= cfg_data;
                default:    scale_recip_reg  <= scale_recip_reg;
            endcase
        end
    end

    assign restart = cfg_we && (cfg_reg_t'(cfg_index) != REG_SCALE);

    // Clamped geometry
    always_comb
    begin
        geom.k = kernel_size_reg;
        if (kernel_size_reg == '0)
        begin
            geom.k = KSZ_W'(1);
        end
        else if (int'(kernel_size_reg) > MAX_KERNEL)
        begin
            geom.k = KSZ_W'(MAX_KERNEL);
        end
        geom.w = image_width_reg;
        if (image_width_reg == '0)
        begin
            geom.w = DIM_W'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            geom.w = DIM_W'(MAX_WIDTH);
        end
        geom.h = image_height_reg;
        if (image_height_reg == '0)
        begin
            geom.h = DIM_W'(1);
        end
        else if (int'(image_height_reg) > MAX_HEIGHT)
        begin
            geom.h = DIM_W'(MAX_HEIGHT);
        end
        geom.down  = DN_W'(geom.k >> 1);
        geom.delay = DLY_W'(DLY_W'(geom.down) * DLY_W'(geom.w)) + DLY_W'(geom.down);
    end

    bmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .geom      (geom),
        .restart   (restart),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    bmf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .pop   (pop),
        .rdata (q_data),
        .count (q_count)
    );

    bmf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_count     (q_count),
        .q_data      (q_data),
        .pop         (pop),
        .scale_recip (scale_recip_reg),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res)
    );

`ifndef NO_ASSERTIONS
    // Front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count < QCW'(QDEPTH) || pop))
        else $error("queue overflow");

    // Full queue holds the input side
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == QCW'(QDEPTH)) |-> pix_stall)
        else $error("input taken with full queue");

    // Fill count stays in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCW'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/bmf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/bmf_front.sv -----
// Front end: accepts words, tracks raster position, runs the line buffer
// and computes the window masks. Uses bmf_pkg and bmf_ram.
`default_nettype none
module bmf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  bmf_pkg::pix_t     pix,
    input  bmf_pkg::geom_t    geom,
    input  logic              restart,
    input  logic [bmf_pkg::QCW-1:0] q_count,
    output logic              push,
    output bmf_pkg::qent_t    push_data
);
    import bmf_pkg::*;

    logic                  accept;
    logic [CW-1:0]         col_pos_reg, col_pos_next;
    logic [DLY_W-1:0]      pre_reg, pre_next;
    logic [RW-1:0]         qr_reg, qr_next;
    logic [CW-1:0]         qc_reg, qc_next;
    logic                  emit, last;
    logic [MAX_KERNEL-1:0] row_mask, col_mask;
    logic [POS_W-1:0]      rd, cd;

    logic                  b_valid_reg;
    logic [PIX_W-1:0]      b_sample_reg;
    logic [CW-1:0]         b_col_reg;
    logic [MAX_KERNEL-1:0] b_row_mask_reg, b_col_mask_reg;
    logic                  b_emit_reg, b_last_reg;
    logic                  byp_reg;
    logic [LB_W-1:0]       byp_data_reg;
    logic [LB_W-1:0]       lb_rdata, lb_data, lb_wdata;
    col_t                  column;

    // Room check: queue fill plus the word in the write stage
    assign pix_stall = ({1'b0, q_count} + (QCW+1)'(b_valid_reg)) >= (QCW+1)'(QDEPTH);
    assign accept    = pix_valid && !pix_stall;

    // Output position bookkeeping
    assign emit = (pre_reg == geom.delay);
    assign last = emit && (DIM_W'(qr_reg) == geom.h - DIM_W'(1))
                       && (DIM_W'(qc_reg) == geom.w - DIM_W'(1));

    // Window masks for the output position
    always_comb
    begin
        rd = POS_W'(qr_reg) + POS_W'(geom.down);
        cd = POS_W'(qc_reg) + POS_W'(geom.down);
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            row_mask[j] = (int'(geom.k) > j) && (rd >= POS_W'(j))
                          && ((rd - POS_W'(j)) < POS_W'(geom.h));
            col_mask[j] = (int'(geom.k) > j) && (cd >= POS_W'(j))
                          && ((cd - POS_W'(j)) < POS_W'(geom.w));
        end
    end

    // Next position
    always_comb
    begin
        col_pos_next = col_pos_reg + CW'(1);
        if ((DIM_W'(col_pos_reg) + DIM_W'(1)) == geom.w)
        begin
            col_pos_next = '0;
        end
        pre_next = pre_reg;
        qr_next  = qr_reg;
        qc_next  = qc_reg;
        if (!emit)
        begin
            pre_next = pre_reg + DLY_W'(1);
        end
        else if ((DIM_W'(qc_reg) + DIM_W'(1)) == geom.w)
        begin
            qc_next = '0;
            qr_next = qr_reg + RW'(1);
        end
        else
        begin
            qc_next = qc_reg + CW'(1);
        end
        if (last)
        begin
            col_pos_next = '0;
            pre_next     = '0;
            qr_next      = '0;
            qc_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            pre_reg     <= '0;
            qr_reg      <= '0;
            qc_reg      <= '0;
            b_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            priority if (restart)
            begin
                col_pos_reg <= '0;
                pre_reg     <= '0;
                qr_reg      <= '0;
                qc_reg      <= '0;
            end
            else if (accept)
            begin
                col_pos_reg <= col_pos_next;
                pre_reg     <= pre_next;
                qr_reg      <= qr_next;
                qc_reg      <= qc_next;
            end
            b_valid_reg <= accept;
            // same column written while being read: forward the new data
            if (accept)
            begin
                byp_reg <= b_valid_reg && (b_col_reg == col_pos_reg);
            end
        end
    end

    // Write-stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sample_reg   <= pix.op ? '0 : pix.pixel;
            b_col_reg      <= col_pos_reg;
            b_row_mask_reg <= row_mask;
            b_col_mask_reg <= col_mask;
            b_emit_reg     <= emit;
            b_last_reg     <= last;
            byp_data_reg   <= lb_wdata;
        end
    end

    // Line buffer: one word per column, holding the previous rows
    bmf_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_col_reg),
        .wdata (lb_wdata),
        .re    (accept),
        .raddr (col_pos_reg),
        .rdata (lb_rdata)
    );

    assign lb_data  = byp_reg ? byp_data_reg : lb_rdata;
    assign column   = {lb_data, b_sample_reg};
    assign lb_wdata = column[MAX_KERNEL-2:0];

    // Push into the queue
    assign push                = b_valid_reg;
    assign push_data.column    = column;
    assign push_data.row_mask  = b_row_mask_reg;
    assign push_data.col_mask  = b_col_mask_reg;
    assign push_data.emit      = b_emit_reg;
    assign push_data.last      = b_last_reg;

endmodule
`default_nettype wire

// ----- rtl/bmf_queue.sv -----
// Short FIFO between front and back of the box mean filter.
// Uses bmf_pkg.
`default_nettype none
module bmf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bmf_pkg::qent_t        wdata,
    input  logic                  pop,
    output bmf_pkg::qent_t        rdata,
    output logic [bmf_pkg::QCW-1:0] count
);
    import bmf_pkg::*;

    qent_t           slots [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + QCW'(push) - QCW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slots[rd_ptr_reg];
    assign count = count_reg;

endmodule
`default_nettype wire

// ----- rtl/bmf_back.sv -----
// Back end: window registers, masked sum tree, scale multiply, output word.
// Uses bmf_pkg.
`default_nettype none
module bmf_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [bmf_pkg::QCW-1:0] q_count,
    input  bmf_pkg::qent_t          q_data,
    output logic                    pop,
    input  logic [bmf_pkg::SCALE_W-1:0] scale_recip,
    output logic                    res_valid,
    input  logic                    res_stall,
    output bmf_pkg::res_t           res
);
    import bmf_pkg::*;

    logic                  en;
    col_t                  win_reg [MAX_KERNEL];
    logic                  s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [MAX_KERNEL-1:0] s1_row_mask_reg, s1_col_mask_reg;
    logic [CSUM_W-1:0]     s2_colsum_reg [MAX_KERNEL];
    logic [CSUM_W-1:0]     colsum [MAX_KERNEL];
    logic                  s2_valid_reg, s2_last_reg;
    logic [MAX_KERNEL-1:0] s2_col_mask_reg;
    logic [SUM_W-1:0]      total;
    logic [SUM_W-1:0]      s3_sum_reg;
    logic                  s3_valid_reg, s3_last_reg;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-FRAC_SHIFT-1:0] mean_wide;
    logic [MEAN_W-1:0]     mean_sat;
    logic                  out_valid_reg;
    res_t                  out_reg;

    // Whole back pipeline moves unless the output word is held
    assign en  = !out_valid_reg || !res_stall;
    assign pop = en && (q_count != '0);

    // Row sums per window column
    always_comb
    begin
        for (int d = 0; d < MAX_KERNEL; d++)
        begin
            colsum[d] = '0;
            for (int j = 0; j < MAX_KERNEL; j++)
            begin
                colsum[d] = colsum[d]
                    + (s1_row_mask_reg[j] ? CSUM_W'(win_reg[d][j]) : CSUM_W'(0));
            end
        end
    end

    // Column total
    always_comb
    begin
        total = '0;
        for (int d = 0; d < MAX_KERNEL; d++)
        begin
            total = total + (s2_col_mask_reg[d] ? SUM_W'(s2_colsum_reg[d]) : SUM_W'(0));
        end
    end

    // Scale and saturate
    assign prod      = PROD_W'(s3_sum_reg) * PROD_W'(scale_recip);
    assign mean_wide = prod[PROD_W-1:FRAC_SHIFT];
    assign mean_sat  = (mean_wide > (PROD_W-FRAC_SHIFT)'(MEAN_MAX)) ? MEAN_MAX
                                                                 : mean_wide[MEAN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // window shift on every popped word
            if (pop)
            begin
                win_reg[0] <= q_data.column;
                for (int d = 1; d < MAX_KERNEL; d++)
                begin
                    win_reg[d] <= win_reg[d-1];
                end
                s1_emit_reg     <= q_data.emit;
                s1_last_reg     <= q_data.last;
                s1_row_mask_reg <= q_data.row_mask;
                s1_col_mask_reg <= q_data.col_mask;
            end
            for (int d = 0; d < MAX_KERNEL; d++)
            begin
                s2_colsum_reg[d] <= colsum[d];
            end
            s2_col_mask_reg    <= s1_col_mask_reg;
            s2_last_reg        <= s1_last_reg;
            s3_sum_reg         <= total;
            s3_last_reg        <= s2_last_reg;
            out_reg.mean_value <= mean_sat;
            out_reg.last       <= s3_last_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
`default_nettype wire

// ----- tb/tb_box_mean_filter_2d.sv -----
// Testbench for the 2-D box mean filter: drives pixel frames and drain words,
// predicts every windowed mean and checks it in order. Depends on rtl/bmf_pkg.sv.
`default_nettype none
module tb_box_mean_filter_2d;
    timeunit 1ns;
    timeprecision 1ps;
    import bmf_pkg::*;

    localparam int HIST = (MAX_KERNEL - 1) * MAX_WIDTH + MAX_KERNEL;

    // Holds predicted means in arrival order and compares them
    class mean_scoreboard;
        res_t pending[$];
        int   errors;
        bit [7:0] hist[HIST];
        int   row, col;
        int   ksz, wd, ht, recip;

        function new();
            errors = 0;
            foreach (hist[i]) hist[i] = 0;
            row = 0; col = 0; ksz = 3; wd = 640; ht = 480; recip = 7282;
        endfunction

        function int clampd(int v, int hi);
            if (v == 0) return 1;
            return v > hi ? hi : v;
        endfunction

        function void write_reg(cfg_reg_t idx, int val);
            case (idx)
                REG_KERNEL: begin ksz = val & 7; row = 0; col = 0; end
                REG_WIDTH:  begin wd = val & 11'h7ff; row = 0; col = 0; end
                REG_HEIGHT: begin ht = val & 11'h7ff; row = 0; col = 0; end
                REG_SCALE:  recip = val & 16'hffff;
            endcase
        endfunction

        // Accepted input word: store sample, queue a mean if one is due
        function void note_word(pix_t w);
            int k, wv, hv, up, dn, dly, total, p, q, r, c, rr, cc;
            longint sum, mean;
            res_t e;
            k = clampd(ksz, MAX_KERNEL);
            wv = clampd(wd, MAX_WIDTH);
            hv = clampd(ht, MAX_HEIGHT);
            up = (k - 1) / 2;
            dn = k - 1 - up;
            dly = dn * wv + dn;
            total = wv * hv;
            p = row * wv + col;
            hist[p % HIST] = w.op ? 8'd0 : w.pixel;
            if (p >= dly && p - dly < total) begin
                q = p - dly;
                r = q / wv;
                c = q % wv;
                sum = 0;
                for (int dr = 0; dr < k; dr++) begin
                    rr = r - up + dr;
                    if (rr < 0 || rr >= hv) continue;
                    for (int dc = 0; dc < k; dc++) begin
                        cc = c - up + dc;
                        if (cc < 0 || cc >= wv) continue;
                        sum += hist[(rr * wv + cc) % HIST];
                    end
                end
                mean = (sum * recip) >> 8;
                if (mean > 65535) mean = 65535;
                e.mean_value = mean[15:0];
                e.last = (q == total - 1);
                pending.push_back(e);
            end
            if (p >= dly + total - 1) begin
                row = 0; col = 0;
            end else begin
                col++;
                if (col >= wv) begin col = 0; row++; end
            end
        endfunction

        function void check_result(res_t got);
            res_t e;
            if (pending.size() == 0) begin
                $error("unexpected result mean_value=%0d last=%0d", got.mean_value, got.last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.mean_value !== e.mean_value) begin
                $error("mean_value: expected %0d actual %0d", e.mean_value, got.mean_value);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %0d actual %0d", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic pix_valid = 0;
    logic pix_stall;
    pix_t pix = '0;
    logic res_valid;
    logic res_stall = 0;
    res_t res;
    logic cfg_we = 0;
    logic [1:0] cfg_index = '0;
    logic [SCALE_W-1:0] cfg_data = '0;

    mean_scoreboard sb = new();
    int hold_mode = 0;   // 2 never stall, any other value random stalls
    int hold_cycles = 0;
    bit drain_burst = 0;

    box_mean_filter_2d dut (.*);

    always #5 clk = ~clk;

    // Output side: check results, stall on its own pattern
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_stall <= 1;
        end
        else if (hold_mode == 2)
            res_stall <= 0;
        else
            res_stall <= ($urandom_range(0, 3) == 0);
    end

    task automatic write_cfg(cfg_reg_t idx, int val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= SCALE_W'(val);
        sb.write_reg(idx, val);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Offer one word and hold it until accepted
    task automatic send_word(bit op, bit [7:0] px);
        pix_t w;
        w.op = op;
        w.pixel = px;
        pix_valid <= 1;
        pix <= w;
        do @(posedge clk); while (pix_stall);
        sb.note_word(w);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0)
        begin
            pix_valid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_empty();
        pix_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // One full frame plus drain words, pixels by the given style
    task automatic run_frame(int style, bit add_noise);
        int k, wv, hv, dn, n;
        bit [7:0] px;
        k = sb.clampd(sb.ksz, MAX_KERNEL);
        wv = sb.clampd(sb.wd, MAX_WIDTH);
        hv = sb.clampd(sb.ht, MAX_HEIGHT);
        dn = k - 1 - (k - 1) / 2;
        n = wv * hv;
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: px = 8'hff;
                1: px = 8'h00;
                default: px = 8'($urandom_range(0, 255));
            endcase
            // a drain word inside the frame counts as zero
            send_word(add_noise && $urandom_range(0, 15) == 0, px);
            if (!drain_burst) idle_gap();
        end
        for (int i = 0; i < dn * wv + dn; i++)
        begin
            send_word(1, 8'($urandom_range(0, 255)));
            idle_gap();
        end
    endtask

    task automatic set_geom(int k, int wv, int hv, int sc);
        write_cfg(REG_KERNEL, k);
        write_cfg(REG_WIDTH, wv);
        write_cfg(REG_HEIGHT, hv);
        write_cfg(REG_SCALE, sc);
    endtask

    initial
    begin
        int k, wv, hv, sent;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes of kernel, size and scale
        set_geom(7, 3, 3, 65535);
        run_frame(0, 0);
        wait_empty();
        set_geom(1, 1, 1, 0);
        run_frame(0, 0);
        wait_empty();
        set_geom(0, 2, 2, 256);    // zero kernel and dims act as 1
        run_frame(2, 0);
        wait_empty();
        set_geom(3, 4, 2, 7282);
        run_frame(2, 1);
        wait_empty();
        write_cfg(REG_SCALE, 1337);
        run_frame(1, 0);
        wait_empty();
        // Oversized width saturates to the maximum, one row tall
        set_geom(1, 2047, 1, 16384);
        run_frame(2, 0);
        wait_empty();

        // Long hold-off while the sender keeps offering
        set_geom(5, 6, 6, 2621);
        hold_cycles = 200;
        drain_burst = 1;
        run_frame(2, 0);
        drain_burst = 0;
        wait_empty();

        // Random frames
        sent = 0;
        while (sent < 300)
        begin
            k = $urandom_range(0, 7);
            wv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
            hv = $urandom_range(0, 7);
            set_geom(k, wv, hv, $urandom_range(0, 65535));
            hold_mode = $urandom_range(0, 3) == 0 ? 2 : 0;
            run_frame(2, $urandom_range(0, 1));
            sent += (wv == 0 ? 1 : wv) * (hv == 0 ? 1 : hv);
            wait_empty();
            if ($urandom_range(0, 1)) write_cfg(REG_SCALE, $urandom_range(0, 65535));
        end
        hold_mode = 0;

        pix_valid <= 0;
        wait_empty();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
